// ===== rtl/core/rphp_pkg.sv =====
// ----------------------------------------------------------------------------
// rphp_pkg
// Shared types and constants for the request header parser.
// ----------------------------------------------------------------------------
package rphp_pkg;

   // Protocol id that announces a two-byte extended id
   localparam logic [6:0]  EXT_MARK       = 7'h7F;

   // Header layout, as byte offsets into the packet
   localparam logic [31:0] LENGTH_BYTES   = 32'd4;
   localparam logic [31:0] PROTO_OFFSET   = 32'd4;
   localparam logic [31:0] EXT_END        = 32'd7;
   localparam logic [31:0] CALL_START     = 32'd5;
   localparam logic [31:0] CALL_START_EXT = 32'd7;
   localparam logic [31:0] METH_START     = 32'd9;
   localparam logic [31:0] METH_START_EXT = 32'd11;
   localparam logic [31:0] HDR_END        = 32'd13;
   localparam logic [31:0] HDR_END_EXT    = 32'd15;

   // Summary checks
   localparam logic [31:0] MIN_PACKET     = 32'd13;
   localparam logic [31:0] MIN_LENGTH     = 32'd9;
   localparam logic [31:0] MIN_EXT_LENGTH = 32'd11;
   localparam logic [31:0] LENGTH_BIAS    = 32'd4;
   localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

   // Default depth of the result queue
   localparam int          OUT_DEPTH      = 4;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_INCOMPLETE = 2'd1,
      STATUS_MALFORMED  = 2'd2
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [6:0]  protocol_id;
      logic [15:0] extended_protocol_id;
      logic [31:0] call_id;
      logic [31:0] method_id;
      logic [31:0] declared_length;
      logic        last;
   } rsp_word_type;

   // Writes into the result queue for one accepted word
   typedef struct packed {
      logic push_a;   // first slot holds a result
      logic push_b;   // second slot holds a result (only with push_a)
   } push_type;

endpackage

// ===== rtl/core/rphp_if.sv =====
// ----------------------------------------------------------------------------
// rphp_req_if / rphp_rsp_if
// Valid/ready channels for packet bytes in and parse results out.
// ----------------------------------------------------------------------------
interface rphp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface rphp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [1:0]  status;
   logic [6:0]  protocol_id;
   logic [15:0] extended_protocol_id;
   logic [31:0] call_id;
   logic [31:0] method_id;
   logic [31:0] declared_length;
   logic        last;

   modport source (
      output valid, output result_kind, output payload_byte, output status,
      output protocol_id, output extended_protocol_id, output call_id,
      output method_id, output declared_length, output last, input ready
   );
   modport sink (
      input valid, input result_kind, input payload_byte, input status,
      input protocol_id, input extended_protocol_id, input call_id,
      input method_id, input declared_length, input last, output ready
   );
endinterface

// ===== rtl/core/rphp_field_capture.sv =====
// ----------------------------------------------------------------------------
// rphp_field_capture
// Header field registers, byte counter and result formation per packet word.
// ----------------------------------------------------------------------------
module rphp_field_capture (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_packet,
   output rphp_pkg::push_type    push,
   output rphp_pkg::rsp_word_type word_a,
   output rphp_pkg::rsp_word_type word_b
);

   logic [31:0] byte_count_ff, byte_count_in;
   logic [31:0] length_ff,     length_in;
   logic [6:0]  proto_ff,      proto_in;
   logic [15:0] ext_proto_ff,  ext_proto_in;
   logic [31:0] call_ff,       call_in;
   logic [31:0] method_ff,     method_in;

   logic [31:0] idx;
   logic        ext_now;
   logic [31:0] call_start;
   logic [31:0] meth_start;
   logic [31:0] hdr_end;
   logic [31:0] call_ofs;
   logic [31:0] meth_ofs;
   logic        in_length;
   logic        in_proto;
   logic        in_ext;
   logic        in_call;
   logic        in_meth;
   logic        is_payload;
   logic [31:0] count_new;
   logic [6:0]  proto_new;
   logic [15:0] ext_new;
   logic [31:0] call_new;
   logic [31:0] method_new;
   logic [31:0] length_new;
   logic        is_ext;
   rphp_pkg::status_type       status;
   rphp_pkg::rsp_word_type     pay_word;
   rphp_pkg::rsp_word_type     sum_word;

   always_comb begin
      idx        = byte_count_ff;
      ext_now    = (proto_ff == rphp_pkg::EXT_MARK);
      call_start = ext_now ? rphp_pkg::CALL_START_EXT : rphp_pkg::CALL_START;
      meth_start = ext_now ? rphp_pkg::METH_START_EXT : rphp_pkg::METH_START;
      hdr_end    = ext_now ? rphp_pkg::HDR_END_EXT : rphp_pkg::HDR_END;
      call_ofs   = idx - call_start;
      meth_ofs   = idx - meth_start;

      // Field decode, in priority order
      in_length  = (idx < rphp_pkg::LENGTH_BYTES);
      in_proto   = !in_length && (idx == rphp_pkg::PROTO_OFFSET);
      in_ext     = !in_length && !in_proto && ext_now && (idx < rphp_pkg::EXT_END);
      in_call    = !in_length && !in_proto && !in_ext
                   && (idx >= call_start) && (idx < meth_start);
      in_meth    = !in_length && !in_proto && !in_ext && !in_call
                   && (idx >= meth_start) && (idx < hdr_end);
      is_payload = !in_length && !in_proto && !in_ext && !in_call && !in_meth;

      // Drop the byte into its lane; untouched lanes hold
      length_new = length_ff;
      proto_new  = proto_ff;
      ext_new    = ext_proto_ff;
      call_new   = call_ff;
      method_new = method_ff;
      for (int k = 0; k < 4; k++) begin
         if (in_length && (idx[1:0] == 2'(k))) length_new[8*k +: 8] = data_byte;
         if (in_call && (call_ofs[1:0] == 2'(k))) call_new[8*k +: 8] = data_byte;
         if (in_meth && (meth_ofs[1:0] == 2'(k))) method_new[8*k +: 8] = data_byte;
      end
      if (in_proto) proto_new = data_byte[6:0];
      if (in_ext && idx[0]) ext_new[7:0] = data_byte;    // offset 5
      if (in_ext && !idx[0]) ext_new[15:8] = data_byte;  // offset 6

      count_new = (byte_count_ff == rphp_pkg::COUNT_MAX) ? byte_count_ff
                                                          : byte_count_ff + 32'd1;
      is_ext    = (proto_new == rphp_pkg::EXT_MARK);

      if ((count_new < rphp_pkg::MIN_PACKET)
          || (length_new != count_new - rphp_pkg::LENGTH_BIAS)) begin
         status = rphp_pkg::STATUS_INCOMPLETE;
      end else if (length_new < rphp_pkg::MIN_LENGTH) begin
         status = rphp_pkg::STATUS_MALFORMED;
      end else if (is_ext && (length_new < rphp_pkg::MIN_EXT_LENGTH)) begin
         status = rphp_pkg::STATUS_MALFORMED;
      end else begin
         status = rphp_pkg::STATUS_OK;
      end

      pay_word              = '0;
      pay_word.result_kind  = rphp_pkg::KIND_PAYLOAD;
      pay_word.payload_byte = data_byte;
      pay_word.status       = rphp_pkg::STATUS_OK;
      pay_word.last         = !end_of_packet;

      sum_word                      = '0;
      sum_word.result_kind          = rphp_pkg::KIND_SUMMARY;
      sum_word.status               = status;
      sum_word.protocol_id          = proto_new;
      sum_word.extended_protocol_id = is_ext ? ext_new : 16'd0;
      sum_word.call_id              = call_new;
      sum_word.method_id            = method_new;
      sum_word.declared_length      = length_new;
      sum_word.last                 = 1'b1;

      // Payload goes ahead of the summary
      word_a      = is_payload ? pay_word : sum_word;
      word_b      = sum_word;
      push.push_a = accept && (is_payload || end_of_packet);
      push.push_b = accept && is_payload && end_of_packet;

      if (accept && end_of_packet) begin
         byte_count_in = '0;
         length_in     = '0;
         proto_in      = '0;
         ext_proto_in  = '0;
         call_in       = '0;
         method_in     = '0;
      end else if (accept) begin
         byte_count_in = count_new;
         length_in     = length_new;
         proto_in      = proto_new;
         ext_proto_in  = ext_new;
         call_in       = call_new;
         method_in     = method_new;
      end else begin
         byte_count_in = byte_count_ff;
         length_in     = length_ff;
         proto_in      = proto_ff;
         ext_proto_in  = ext_proto_ff;
         call_in       = call_ff;
         method_in     = method_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         length_ff     <= '0;
         proto_ff      <= '0;
         ext_proto_ff  <= '0;
         call_ff       <= '0;
         method_ff     <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         length_ff     <= length_in;
         proto_ff      <= proto_in;
         ext_proto_ff  <= ext_proto_in;
         call_ff       <= call_in;
         method_ff     <= method_in;
      end
   end

endmodule

// ===== rtl/core/rphp_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// rphp_rsp_queue
// Small result queue: takes up to two words a cycle, gives one a cycle when popped.
// ----------------------------------------------------------------------------
module rphp_rsp_queue #(
   parameter int Depth = rphp_pkg::OUT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rphp_pkg::push_type     push,
   input  rphp_pkg::rsp_word_type word_a,
   input  rphp_pkg::rsp_word_type word_b,
   input  logic                   pop,
   output rphp_pkg::rsp_word_type head,
   output logic                   not_empty,
   output logic                   room
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   rphp_pkg::rsp_word_type entries_ff [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic [PtrW-1:0] wr_next1;
   logic [PtrW-1:0] wr_next2;
   logic [PtrW-1:0] rd_next;

   always_comb begin
      wr_next1 = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      wr_next2 = (wr_next1 == PtrW'(Depth - 1)) ? '0 : wr_next1 + PtrW'(1);
      rd_next  = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);

      if (push.push_b)      wr_ptr_in = wr_next2;
      else if (push.push_a) wr_ptr_in = wr_next1;
      else                  wr_ptr_in = wr_ptr_ff;

      rd_ptr_in = pop ? rd_next : rd_ptr_ff;
      count_in  = count_ff + CntW'(push.push_a) + CntW'(push.push_b) - CntW'(pop);

      head      = entries_ff[rd_ptr_ff];
      not_empty = (count_ff != '0);
      // Leave space for a payload word and a summary from the same byte
      room      = (count_ff <= CntW'(Depth - 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_a) entries_ff[wr_ptr_ff] <= word_a;
      if (push.push_b) entries_ff[wr_next1]  <= word_b;
   end

endmodule

// ===== rtl/core/rpc_request_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// rpc_request_header_parser_core
// Byte-stream parser for remote-call request headers.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one packet byte per word plus an end-of-packet flag.
//   The first 13 bytes (15 with an extended protocol id) form the header:
//   length, protocol byte, optional extended id, call id, method id.
//   rsp_bus returns a payload word for every byte after the header and a
//   summary word on the final byte, after that byte's payload word if any.
//   'last' marks the final result word caused by one request word.
// Timing:
//   Each result word is registered in the result queue when its byte is
//   taken, and rsp_bus shows the queue head; a summary behind a payload
//   word from the same byte follows it out. One request word is taken
//   every cycle while rsp_bus.ready stays high: header bytes make no
//   result word, so the second word of a final payload byte drains
//   while the next packet's header comes in. The result queue depth
//   (OutDepth) sets how long the input keeps moving while rsp_bus is held.
// Reset: clears the header fields, the byte counter and the result queue.
// Stall: when rsp_bus.ready stays low the queue fills and req_bus.ready
//   drops until space for two result words is back.
// ----------------------------------------------------------------------------
module rpc_request_header_parser_core #(
   parameter int OutDepth = rphp_pkg::OUT_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   rphp_req_if.sink   req_bus,
   rphp_rsp_if.source rsp_bus
);

   logic                   req_accept;
   logic                   rsp_pop;
   logic                   queue_room;
   logic                   queue_valid;
   rphp_pkg::push_type     push;
   rphp_pkg::rsp_word_type word_a;
   rphp_pkg::rsp_word_type word_b;
   rphp_pkg::rsp_word_type head;

   // Take a byte only when the queue can hold both results it may cause
   assign req_bus.ready = queue_room;
   assign req_accept    = req_bus.valid && queue_room;
   assign rsp_pop       = queue_valid && rsp_bus.ready;

   // Header field registers and result formation
   rphp_field_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .data_byte     (req_bus.data_byte),
      .end_of_packet (req_bus.end_of_packet),
      .push          (push),
      .word_a        (word_a),
      .word_b        (word_b)
   );

   // Result queue parts the two handshakes
   rphp_rsp_queue #(
      .Depth (OutDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .word_a    (word_a),
      .word_b    (word_b),
      .pop       (rsp_pop),
      .head      (head),
      .not_empty (queue_valid),
      .room      (queue_room)
   );

   // Drive the result channel from the queue head
   assign rsp_bus.valid                = queue_valid;
   assign rsp_bus.result_kind          = head.result_kind;
   assign rsp_bus.payload_byte         = head.payload_byte;
   assign rsp_bus.status               = head.status;
   assign rsp_bus.protocol_id          = head.protocol_id;
   assign rsp_bus.extended_protocol_id = head.extended_protocol_id;
   assign rsp_bus.call_id              = head.call_id;
   assign rsp_bus.method_id            = head.method_id;
   assign rsp_bus.declared_length      = head.declared_length;
   assign rsp_bus.last                 = head.last;

endmodule

// ===== verif/tb_rpc_request_header_parser_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rpc_request_header_parser_core
// Self-checking bench: streams request packets into the parser and checks
// every payload and summary word against an in-bench model of the parser.
// ----------------------------------------------------------------------------
module tb_rpc_request_header_parser_core;

   localparam int PHASE_WORDS   = 400;   // request words per idling phase
   localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
   localparam int SETTLE_CYCLES = 16;    // quiet cycles before the verdict

   typedef logic [7:0] octet_queue_type[$];

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the header fields of the packet in flight, predicts
   // the result words of each accepted byte and checks them in order.
   // -------------------------------------------------------------------------
   class header_scoreboard;
      logic [31:0]            byte_count;
      logic [31:0]            length_val;
      logic [6:0]             proto_val;
      logic [15:0]            ext_id_val;
      logic [31:0]            call_val;
      logic [31:0]            method_val;
      rphp_pkg::rsp_word_type expected_words[$];
      int                     mismatches;

      function new();
         clear_packet();
         mismatches = 0;
      endfunction

      function void clear_packet();
         byte_count = '0;
         length_val = '0;
         proto_val  = '0;
         ext_id_val = '0;
         call_val   = '0;
         method_val = '0;
      endfunction

      function void note_byte(logic [7:0] octet, logic eop);
         logic [31:0]            idx;
         logic [31:0]            hdr_len;
         logic [31:0]            call_at;
         logic [31:0]            meth_at;
         logic                   ext;
         int                     off;
         rphp_pkg::rsp_word_type w;
         idx     = byte_count;
         ext     = (proto_val == rphp_pkg::EXT_MARK);
         hdr_len = ext ? rphp_pkg::HDR_END_EXT : rphp_pkg::HDR_END;
         call_at = ext ? rphp_pkg::CALL_START_EXT : rphp_pkg::CALL_START;
         meth_at = ext ? rphp_pkg::METH_START_EXT : rphp_pkg::METH_START;
         if (idx < rphp_pkg::LENGTH_BYTES) begin
            off = idx;
            length_val[8*off +: 8] = octet;
         end else if (idx == rphp_pkg::PROTO_OFFSET) begin
            proto_val = octet[6:0];
         end else if (ext && idx < rphp_pkg::EXT_END) begin
            off = idx - rphp_pkg::CALL_START;
            ext_id_val[8*off +: 8] = octet;
         end else if (idx >= call_at && idx < meth_at) begin
            off = idx - call_at;
            call_val[8*off +: 8] = octet;
         end else if (idx >= meth_at && idx < hdr_len) begin
            off = idx - meth_at;
            method_val[8*off +: 8] = octet;
         end else begin
            w              = '0;
            w.result_kind  = rphp_pkg::KIND_PAYLOAD;
            w.status       = rphp_pkg::STATUS_OK;
            w.payload_byte = octet;
            w.last         = !eop;
            expected_words = {expected_words, w};
         end

         if (byte_count != rphp_pkg::COUNT_MAX) byte_count++;

         if (eop) begin
            ext           = (proto_val == rphp_pkg::EXT_MARK);
            w             = '0;
            w.result_kind = rphp_pkg::KIND_SUMMARY;
            if (byte_count < rphp_pkg::MIN_PACKET
                || length_val != byte_count - rphp_pkg::LENGTH_BIAS)
               w.status = rphp_pkg::STATUS_INCOMPLETE;
            else if (length_val < rphp_pkg::MIN_LENGTH)
               w.status = rphp_pkg::STATUS_MALFORMED;
            else if (ext && length_val < rphp_pkg::MIN_EXT_LENGTH)
               w.status = rphp_pkg::STATUS_MALFORMED;
            else
               w.status = rphp_pkg::STATUS_OK;
            w.protocol_id          = proto_val;
            w.extended_protocol_id = ext ? ext_id_val : 16'h0;
            w.call_id              = call_val;
            w.method_id            = method_val;
            w.declared_length      = length_val;
            w.last                 = 1'b1;
            expected_words         = {expected_words, w};
            clear_packet();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(rphp_pkg::rsp_word_type got);
         rphp_pkg::rsp_word_type want;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: kind %0d byte 0x%0h",
                   got.result_kind, got.payload_byte);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("status", want.status, got.status);
         compare_field("protocol_id", want.protocol_id, got.protocol_id);
         compare_field("extended_protocol_id", want.extended_protocol_id,
                       got.extended_protocol_id);
         compare_field("call_id", want.call_id, got.call_id);
         compare_field("method_id", want.method_id, got.method_id);
         compare_field("declared_length", want.declared_length, got.declared_length);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;

   rphp_req_if req_bus ();
   rphp_rsp_if rsp_bus ();

   rpc_request_header_parser_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   header_scoreboard sb;
   int               send_idle_pct;
   int               rsp_idle_pct;
   int               sent_words;
   int               stall_cycles;

   wire req_take = req_bus.valid && req_bus.ready;
   wire rsp_take = rsp_bus.valid && rsp_bus.ready;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: drop ready at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Note each accepted request word before checking the result word of the
   // same edge; a result is registered in the queue, so it always trails its byte.
   always @(posedge clock) begin
      rphp_pkg::rsp_word_type got;
      if (!reset) begin
         if (req_take) sb.note_byte(req_bus.data_byte, req_bus.end_of_packet);
         if (rsp_take) begin
            got.result_kind          = rphp_pkg::kind_type'(rsp_bus.result_kind);
            got.payload_byte         = rsp_bus.payload_byte;
            got.status               = rphp_pkg::status_type'(rsp_bus.status);
            got.protocol_id          = rsp_bus.protocol_id;
            got.extended_protocol_id = rsp_bus.extended_protocol_id;
            got.call_id              = rsp_bus.call_id;
            got.method_id            = rsp_bus.method_id;
            got.declared_length      = rsp_bus.declared_length;
            got.last                 = rsp_bus.last;
            sb.check_result(got);
         end
      end
   end

   // Watchdog: give up when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || req_take || rsp_take) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("rpc_request_header_parser_core regression: fail");
            $finish;
         end
      end
   end

   // Drive one request word; enter and leave at a falling edge. Hold valid
   // high across back-to-back words.
   task automatic send_word(input logic [7:0] octet, input logic eop);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= octet;
      req_bus.end_of_packet <= eop;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent_words++;
   endtask

   // Hold the sender until every predicted word has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_words.size() != 0);
      @(negedge clock);
   endtask

   task automatic send_packet(input octet_queue_type pkt);
      foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
   endtask

   // Build a well-formed request: length field matches the byte count, and
   // the extended id is present when the protocol byte asks for it.
   function automatic octet_queue_type make_request(logic [7:0] proto,
                                                    logic [15:0] ext_id,
                                                    logic [31:0] call,
                                                    logic [31:0] method,
                                                    int payload_len);
      octet_queue_type pkt;
      logic [31:0]     len;
      logic            ext;
      ext = (proto[6:0] == rphp_pkg::EXT_MARK);
      len = (ext ? rphp_pkg::HDR_END_EXT : rphp_pkg::HDR_END) + payload_len
            - rphp_pkg::LENGTH_BIAS;
      for (int i = 0; i < 4; i++) pkt = {pkt, len[8*i +: 8]};
      pkt = {pkt, proto};
      if (ext) begin
         pkt = {pkt, ext_id[7:0]};
         pkt = {pkt, ext_id[15:8]};
      end
      for (int i = 0; i < 4; i++) pkt = {pkt, call[8*i +: 8]};
      for (int i = 0; i < 4; i++) pkt = {pkt, method[8*i +: 8]};
      repeat (payload_len) pkt = {pkt, 8'($urandom)};
      return pkt;
   endfunction

   // Mostly valid requests with random content; the rest are short packets
   // with an extended id, length errors and plain noise.
   task automatic send_random_packet();
      octet_queue_type pkt;
      logic [7:0]      proto;
      logic [31:0]     len;
      int              pick;
      int              cut;
      int              payload_len;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 30)
         proto = {1'($urandom), rphp_pkg::EXT_MARK};
      else
         proto = {1'($urandom), 7'($urandom_range(rphp_pkg::EXT_MARK - 1))};
      payload_len = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(40, 9);
      pkt = make_request(proto, 16'($urandom), $urandom, $urandom, payload_len);
      if (pick >= 90) begin
         // noise: random bytes, random length
         pkt.delete();
         repeat ($urandom_range(20, 1)) pkt = {pkt, 8'($urandom)};
      end else if (pick >= 80) begin
         // corrupt one byte of the length field
         pkt[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
      end else if (pick >= 70) begin
         // extended id, but the packet stops before the method id is whole
         pkt = make_request({1'($urandom), rphp_pkg::EXT_MARK}, 16'($urandom), $urandom,
                            $urandom, 0);
         cut = $urandom_range(rphp_pkg::HDR_END_EXT - 1, rphp_pkg::MIN_PACKET);
         pkt = pkt[0:cut-1];
         len = cut - rphp_pkg::LENGTH_BIAS;
         for (int i = 0; i < 4; i++) pkt[i] = len[8*i +: 8];
      end
      send_packet(pkt);
      if ($urandom_range(99) < 3) wait_drained();
   endtask

   initial begin
      octet_queue_type pkt;
      logic [31:0]     len;
      int              phase_end;

      sb                    = new();
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.data_byte     = 8'h00;
      req_bus.end_of_packet = 1'b0;
      send_idle_pct         = 0;
      rsp_idle_pct          = 0;
      sent_words            = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a packet of one byte ends inside the length field.
      pkt = {8'hFF};
      send_packet(pkt);

      // Directed: extended id with a 13-byte packet; length is consistent
      // but too short for the extended header, method id only half there.
      pkt = make_request(8'h7F, 16'hFFFF, 32'hFFFF_FFFF, 32'hA5C3_0FF0, 0);
      pkt = pkt[0:rphp_pkg::MIN_PACKET-1];
      len = rphp_pkg::MIN_PACKET - rphp_pkg::LENGTH_BIAS;
      for (int i = 0; i < 4; i++) pkt[i] = len[8*i +: 8];
      send_packet(pkt);

      // Directed: plain header with the top bit of the protocol byte set,
      // one payload byte on the final byte, so two result words at once.
      send_packet(make_request(8'h80, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1));
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               rsp_idle_pct  = 56;
            end
            1: begin
               send_idle_pct = 56;
               rsp_idle_pct  = 7;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         phase_end = sent_words + PHASE_WORDS;
         while (sent_words < phase_end) send_random_packet();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_words.size() != 0)
         $error("%0d result words never returned", sb.expected_words.size());
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("rpc_request_header_parser_core regression: pass");
      end else begin
         $display("rpc_request_header_parser_core regression: fail");
      end
      $finish;
   end
endmodule
